### sv/ultrasonic_ranger_controller_unit_defines.svh
// Assertion macros shared by the ultrasonic ranger controller RTL.
`ifndef ULTRASONIC_RANGER_CONTROLLER_UNIT_DEFINES_SVH
`define ULTRASONIC_RANGER_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a property every clock edge outside reset.
`define URC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property every clock edge, reset included.
`define URC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define URC_ASSERT(name, prop, msg)
`define URC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### sv/urc_pkg.sv
// Types, codes and the digit lookup function of the ultrasonic ranger controller.
package urc_pkg;

  // Configuration register indexes and widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q24      = 2'd3;

  localparam logic [15:0] TRIGGER_TICKS_RST  = 16'd160;
  localparam logic [27:0] SETTLE_TICKS_RST   = 28'd16000000;
  localparam logic [23:0] MAX_ECHO_TICKS_RST = 24'hFFFFFF;
  localparam logic [15:0] SCALE_Q24_RST      = 16'd17826;

  // Sequencer phases
  localparam logic [2:0] PH_BEGIN     = 3'd0;
  localparam logic [2:0] PH_HOLD      = 3'd1;
  localparam logic [2:0] PH_SETTLE    = 3'd2;
  localparam logic [2:0] PH_TRIGGER   = 3'd3;
  localparam logic [2:0] PH_WAIT_ECHO = 3'd4;
  localparam logic [2:0] PH_COUNT     = 3'd5;

  // Status LED codes, green/blue/red in bits 2..0
  localparam logic [2:0] LED_OFF     = 3'd0;
  localparam logic [2:0] LED_IDLE    = 3'd4;
  localparam logic [2:0] LED_PAUSED  = 3'd5;
  localparam logic [2:0] LED_MEASURE = 3'd1;

  localparam logic [6:0] SEG_OFF = 7'h7F;

  localparam int unsigned QUEUE_DEPTH = 4;

  // One tick's worth of sequencer output, handed from front to back
  typedef struct packed {
    logic        trigger;
    logic [2:0]  led;
    logic        done;
    logic [23:0] echo_width;
  } urc_entry_t;

  // Active-low gfedcba pattern of one decimal digit
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h10;
      default: pat = SEG_OFF;
    endcase
    return pat;
  endfunction

endpackage

### sv/ultrasonic_ranger_controller_unit.sv
// Top level of the ultrasonic ranger controller: configuration registers and stream ports.
// Each input word is one tick of the timing reference carrying the echo level and the
// hold button; each tick yields exactly one output word with the trigger level, status
// LEDs, three active-low gfedcba digits, the last distance in centimetres and a tuser
// flag set on the tick a new distance is latched. The sequencer pauses while the button
// is held, waits settle_ticks, pulses the trigger for trigger_ticks, then counts the
// echo high time (saturating at max_echo_ticks) and converts it with
// cm = (count * scale_q24) >> 24. One word is accepted and one delivered every clock
// cycle while the output is not stalled; an accepted word is written into the queue
// at the accepting edge and read straight into the first of three arithmetic stages
// for the scaling multiply and two decimal splits, followed by the output register.
// The queue between sequencer and arithmetic holds QueueDepth words; while the output
// is stalled the input keeps flowing until the queue fills, and a full queue drops
// tready for the cycle in which the output resumes.
// Write configuration only while no word is in flight.
module ultrasonic_ranger_controller_unit
  import urc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick stream in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // [0] echo, [1] hold_button, rest zero
  // result stream out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] trigger, [3:1] led_bits, [10:4] seg_hundreds, [17:11] seg_tens,
  // [24:18] seg_ones, [39:25] distance_cm
  output logic [39:0]           m_axis_tdata_o,
  output logic [0:0]            m_axis_tuser_o   // [0] measure_done
);

  logic [15:0] trigger_ticks_q;
  logic [27:0] settle_ticks_q;
  logic [23:0] max_echo_ticks_q;
  logic [15:0] scale_q24_q;

  logic       q_full, q_empty, push, pop;
  urc_entry_t push_entry, pop_entry;

  // Configuration registers; writes are registered, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_ticks_q  <= TRIGGER_TICKS_RST;
      settle_ticks_q   <= SETTLE_TICKS_RST;
      max_echo_ticks_q <= MAX_ECHO_TICKS_RST;
      scale_q24_q      <= SCALE_Q24_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIGGER_TICKS:  trigger_ticks_q  <= cfg_data_i[15:0];
        CFG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data_i[27:0];
        CFG_MAX_ECHO_TICKS: max_echo_ticks_q <= cfg_data_i[23:0];
        CFG_SCALE_Q24:      scale_q24_q      <= cfg_data_i[15:0];
        default:            ;
      endcase
    end
  end

  // Sequencer: one step per accepted tick
  urc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (s_axis_tvalid_i),
    .tick_ready_o     (s_axis_tready_o),
    .echo_i           (s_axis_tdata_i[0]),
    .hold_i           (s_axis_tdata_i[1]),
    .trigger_ticks_i  (trigger_ticks_q),
    .settle_ticks_i   (settle_ticks_q),
    .max_echo_ticks_i (max_echo_ticks_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  // Decouple sequencer from the arithmetic pipeline
  urc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_entry)
  );

  logic back_ready;
  assign pop = back_ready && !q_empty;

  // Distance scaling, digit split and output register
  urc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (!q_empty),
    .in_ready_o      (back_ready),
    .in_entry_i      (pop_entry),
    .scale_q24_i     (scale_q24_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

### sv/urc_front.sv
// Front end: takes one tick per word and steps the measurement sequencer.
`include "ultrasonic_ranger_controller_unit_defines.svh"
module urc_front
  import urc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_valid_i,
  output logic        tick_ready_o,
  input  logic        echo_i,
  input  logic        hold_i,
  input  logic [15:0] trigger_ticks_i,
  input  logic [27:0] settle_ticks_i,
  input  logic [23:0] max_echo_ticks_i,
  input  logic        q_full_i,
  output logic        push_o,
  output urc_entry_t  entry_o
);

  logic [2:0]  phase_q, phase_d;
  logic [27:0] cnt_q, cnt_d;
  logic [23:0] ew_q, ew_d;
  logic [2:0]  led_q, led_d;
  logic        done;

  assign tick_ready_o = !q_full_i;
  assign push_o       = tick_valid_i && !q_full_i;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ew_d    = ew_q;
    led_d   = led_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_HOLD: begin
        if (hold_i) begin
          led_d = LED_PAUSED;
        end else begin
          phase_d = PH_SETTLE;
          cnt_d   = '0;
        end
      end
      PH_SETTLE: begin
        if (cnt_q >= settle_ticks_i) begin
          led_d   = LED_MEASURE;
          cnt_d   = 28'd1;
          phase_d = PH_TRIGGER;
        end else begin
          cnt_d = cnt_q + 28'd1;
        end
      end
      PH_TRIGGER: begin
        if (cnt_q >= {12'd0, trigger_ticks_i}) begin
          cnt_d   = '0;
          phase_d = PH_WAIT_ECHO;
        end else begin
          cnt_d = cnt_q + 28'd1;
        end
      end
      PH_WAIT_ECHO: begin
        if (echo_i) begin
          ew_d    = '0;
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo_i) begin
          ew_d = (ew_q < max_echo_ticks_i) ? ew_q + 24'd1 : max_echo_ticks_i;
        end else begin
          done    = 1'b1;
          phase_d = PH_BEGIN;
        end
      end
      default: begin
        // begin phase, and any code that means nothing
        cnt_d = '0;
        if (hold_i) begin
          led_d   = LED_PAUSED;
          phase_d = PH_HOLD;
        end else begin
          led_d   = LED_IDLE;
          phase_d = PH_SETTLE;
        end
      end
    endcase
  end

  assign entry_o.trigger    = (phase_d == PH_TRIGGER);
  assign entry_o.led        = led_d;
  assign entry_o.done       = done;
  assign entry_o.echo_width = ew_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      cnt_q   <= '0;
      ew_q    <= '0;
      led_q   <= LED_OFF;
    end else if (push_o) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ew_q    <= ew_d;
      led_q   <= led_d;
    end
  end

  `URC_ASSERT(a_settle_to_trigger,
    push_o && phase_q == PH_SETTLE && cnt_q >= settle_ticks_i
      |=> phase_q == PH_TRIGGER && cnt_q == 28'd1 && led_q == LED_MEASURE,
    "settle expiry did not start the trigger pulse")

endmodule

### sv/urc_queue.sv
// Short FIFO of sequencer words between front and back.
`include "ultrasonic_ranger_controller_unit_defines.svh"
module urc_queue
  import urc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  urc_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output urc_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  urc_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `URC_ASSERT(a_count_bound, count_q <= FullCnt,
    "queue fill count beyond depth")
  `URC_ASSERT(a_count_track,
    push_i && !full_o && !(pop_i && !empty_o) |=> count_q == $past(count_q) + CntW'(1),
    "queue fill count lost a push")

endmodule

### sv/urc_back.sv
// Back end: turns echo widths into centimetres and digits, holds the output word.
`include "ultrasonic_ranger_controller_unit_defines.svh"
module urc_back
  import urc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  urc_entry_t  in_entry_i,
  input  logic [15:0] scale_q24_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o
);

  logic en;

  // stage valids (control) and payloads
  logic        s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic        s1_trig_q, s2_trig_q, s3_trig_q, out_trig_q;
  logic [2:0]  s1_led_q, s2_led_q, s3_led_q, out_led_q;
  logic        s1_done_q, s2_done_q, s3_done_q, out_done_q;
  logic [39:0] s1_prod_q;
  logic [14:0] s2_cm_q, s3_cm_q;
  logic [8:0]  s2_q100_q, s3_q100_q;
  logic [11:0] s2_q10_q, s3_q10_q;
  logic [5:0]  s3_q1000_q;
  logic [8:0]  s3_q100t_q;

  // display state
  logic [14:0] dist_q;
  logic [6:0]  seg_h_q, seg_t_q, seg_o_q;

  logic [15:0] cm_raw;
  logic [14:0] cm_sat;
  logic [27:0] mul_q100;
  logic [30:0] mul_q10;
  logic [16:0] mul_q1000;
  logic [24:0] mul_q100t;
  logic [8:0]  h_rem;
  logic [11:0] t_rem;
  logic [14:0] o_rem;

  assign en         = !out_valid_q || m_axis_tready_i;
  assign in_ready_o = en;

  // Stage 2: scale back to cm, saturate, divide by 100 and by 10 via reciprocals
  assign cm_raw   = s1_prod_q[39:24];
  assign cm_sat   = cm_raw[15] ? 15'h7FFF : cm_raw[14:0];
  assign mul_q100 = 28'(cm_sat) * 28'(13'd5243);
  assign mul_q10  = 31'(cm_sat) * 31'(16'd52429);

  // Stage 3: second decimal split
  assign mul_q1000 = 17'(s2_q100_q) * 17'(8'd205);
  assign mul_q100t = 25'(s2_q10_q) * 25'(13'd6554);

  // Output stage: remainders by shift-add times ten
  assign h_rem = s3_q100_q - ({s3_q1000_q, 3'b000} + {2'b00, s3_q1000_q, 1'b0});
  assign t_rem = s3_q10_q - ({s3_q100t_q, 3'b000} + {2'b00, s3_q100t_q, 1'b0}) ;
  assign o_rem = s3_cm_q - ({s3_q10_q, 3'b000} + {2'b00, s3_q10_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      seg_h_q     <= SEG_OFF;
      seg_t_q     <= SEG_OFF;
      seg_o_q     <= SEG_OFF;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      if (s3_valid_q && s3_done_q) begin
        dist_q  <= s3_cm_q;
        seg_h_q <= seg_of(h_rem[3:0]);
        seg_t_q <= seg_of(t_rem[3:0]);
        seg_o_q <= seg_of(o_rem[3:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_trig_q   <= in_entry_i.trigger;
      s1_led_q    <= in_entry_i.led;
      s1_done_q   <= in_entry_i.done;
      s1_prod_q   <= 40'(in_entry_i.echo_width) * 40'(scale_q24_i);
      s2_trig_q   <= s1_trig_q;
      s2_led_q    <= s1_led_q;
      s2_done_q   <= s1_done_q;
      s2_cm_q     <= cm_sat;
      s2_q100_q   <= mul_q100[27:19];
      s2_q10_q    <= mul_q10[30:19];
      s3_trig_q   <= s2_trig_q;
      s3_led_q    <= s2_led_q;
      s3_done_q   <= s2_done_q;
      s3_cm_q     <= s2_cm_q;
      s3_q100_q   <= s2_q100_q;
      s3_q10_q    <= s2_q10_q;
      s3_q1000_q  <= mul_q1000[16:11];
      s3_q100t_q  <= mul_q100t[24:16];
      out_trig_q  <= s3_trig_q;
      out_led_q   <= s3_led_q;
      out_done_q  <= s3_done_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {dist_q, seg_o_q, seg_t_q, seg_h_q, out_led_q, out_trig_q};
  assign m_axis_tuser_o  = out_done_q;

  `URC_ASSERT(a_done_digits_lit,
    out_valid_q && out_done_q |-> seg_h_q != SEG_OFF && seg_t_q != SEG_OFF && seg_o_q != SEG_OFF,
    "measurement word carries a blank digit")

endmodule

### dv/ultrasonic_ranger_controller_unit_tb.sv
// Self-checking testbench for the ultrasonic ranger controller stream ports.
`timescale 1ns / 100ps

module ultrasonic_ranger_controller_unit_tb;
  import urc_pkg::*;

  // Cycles allowed with no word moving on either side before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Slack after the last reading: the trip through the pipe plus margin
  localparam int unsigned PIPE_SLACK = 8;
  // Least number of ticks of random stimulus in each configuration phase
  localparam int unsigned PHASE_TICKS = 170;
  localparam int unsigned RANDOM_PHASES = 5;

  // Active-low gfedcba pattern for each decimal digit
  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  // One output word, unpacked into its fields
  typedef struct packed {
    logic        trigger;
    logic [2:0]  led;
    logic [6:0]  seg_hundreds;
    logic [6:0]  seg_tens;
    logic [6:0]  seg_ones;
    logic [14:0] distance_cm;
    logic        measure_done;
  } reading_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // One line of the directed stimulus table: either a run of identical ticks or a
  // register write. Typed rows carry the reading read straight off the spec.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [27:0]          reg_val;
    logic                 echo;
    logic                 hold;
    logic [31:0]          reps;
    logic                 typed;
    reading_t             want;
  } plan_row_t;

  localparam reading_t NO_READING = '0;
  // Default config after reset: first tick leaves BEGIN showing green, digits blank
  localparam reading_t AFTER_RESET =
    '{1'b0, LED_IDLE, SEG_OFF, SEG_OFF, SEG_OFF, 15'd0, 1'b0};
  // Echo counter pinned at zero by a zero ceiling: latch shows 000
  localparam reading_t ZERO_LATCH =
    '{1'b0, LED_MEASURE, 7'h40, 7'h40, 7'h40, 15'd0, 1'b1};
  // Button held on the tick after the latch: pause, yellow
  localparam reading_t ZERO_PAUSE =
    '{1'b0, LED_PAUSED, 7'h40, 7'h40, 7'h40, 15'd0, 1'b0};

  localparam int unsigned PLAN_LEN = 28;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset config; settle is far off, so echo and button are ignored
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd1, 1'b1, AFTER_RESET},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b1, 32'd1, 1'b1, AFTER_RESET},
    // longest settle, then jump to zero settle with the counter already past it
    '{ROW_WRITE, CFG_SETTLE_TICKS, 28'hFFFFFFF, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd20, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 28'd0, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_MAX_ECHO_TICKS, 28'd0, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_SCALE_Q24, 28'd65535, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_SETTLE_TICKS, 28'd0, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    // zero-length trigger acts as one tick, echo held at a zero ceiling
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd4, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b0, 32'd5, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd1, 1'b1, ZERO_LATCH},
    // pause and release
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b1, 32'd1, 1'b1, ZERO_PAUSE},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b1, 32'd3, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd1, 1'b0, NO_READING},
    // longer trigger pulse, then an uncapped echo
    '{ROW_WRITE, CFG_MAX_ECHO_TICKS, 28'hFFFFFF, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 28'd20, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd24, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b0, 32'd100, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd1, 1'b0, NO_READING},
    // echo runs past its ceiling
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 28'd1, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_WRITE, CFG_MAX_ECHO_TICKS, 28'd30, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd6, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b0, 32'd50, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd2, 1'b0, NO_READING},
    // zero scale turns any echo into zero centimetres
    '{ROW_WRITE, CFG_SCALE_Q24, 28'd0, 1'b0, 1'b0, 32'd0, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd6, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b1, 1'b0, 32'd40, 1'b0, NO_READING},
    '{ROW_TICK,  '0, 28'd0, 1'b0, 1'b0, 32'd2, 1'b0, NO_READING}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i = '0;   // [0] echo, [1] hold_button
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [0] trigger, [3:1] led_bits, [10:4] seg_hundreds, [17:11] seg_tens,
  // [24:18] seg_ones, [39:25] distance_cm
  logic [39:0]           m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;        // [0] measure_done

  // Shadow configuration
  logic [15:0] trig_len_cfg;
  logic [27:0] settle_len_cfg;
  logic [23:0] echo_cap_cfg;
  logic [15:0] scale_cfg;

  // Shadow sequencer state
  logic [2:0]  seq_phase;
  logic [27:0] tick_cnt;
  logic [23:0] echo_cnt;
  logic [2:0]  led_now;
  logic [6:0]  digit_segs [3];
  logic [14:0] last_cm;

  reading_t    expected_readings [$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned stalled_cycles = 0;
  bit          calm = 1'b0;   // no idling on either side while set

  ultrasonic_ranger_controller_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Bring the shadow model to its reset state
  function automatic void reset_ranger();
    trig_len_cfg   = TRIGGER_TICKS_RST;
    settle_len_cfg = SETTLE_TICKS_RST;
    echo_cap_cfg   = MAX_ECHO_TICKS_RST;
    scale_cfg      = SCALE_Q24_RST;
    seq_phase      = PH_BEGIN;
    tick_cnt       = '0;
    echo_cnt       = '0;
    led_now        = LED_OFF;
    last_cm        = '0;
    foreach (digit_segs[i]) digit_segs[i] = SEG_OFF;
  endfunction

  // Advance the shadow sequencer by one tick and return the word it shows afterwards
  function automatic reading_t advance_ranger(input logic echo, input logic hold);
    reading_t    r;
    logic [39:0] product;
    logic [15:0] cm_raw;
    logic        done;
    done = 1'b0;
    case (seq_phase)
      PH_HOLD: begin
        if (hold) begin
          led_now = LED_PAUSED;
        end else begin
          seq_phase = PH_SETTLE;
          tick_cnt  = '0;
        end
      end
      PH_SETTLE: begin
        if (tick_cnt >= settle_len_cfg) begin
          led_now   = LED_MEASURE;
          tick_cnt  = 28'd1;
          seq_phase = PH_TRIGGER;
        end else begin
          tick_cnt = tick_cnt + 28'd1;
        end
      end
      PH_TRIGGER: begin
        // a zero length trips on the first compare, same as one tick
        if (tick_cnt >= {12'd0, trig_len_cfg}) begin
          tick_cnt  = '0;
          seq_phase = PH_WAIT_ECHO;
        end else begin
          tick_cnt = tick_cnt + 28'd1;
        end
      end
      PH_WAIT_ECHO: begin
        if (echo) begin
          echo_cnt  = '0;
          seq_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          // saturate at the ceiling; a zero ceiling pins the count at zero
          if (echo_cnt < echo_cap_cfg) echo_cnt = echo_cnt + 24'd1;
          else echo_cnt = echo_cap_cfg;
        end else begin
          product = 40'(echo_cnt) * 40'(scale_cfg);
          cm_raw  = product[39:24];
          last_cm = cm_raw[15] ? 15'h7FFF : cm_raw[14:0];
          // hundreds digit drops anything above it
          digit_segs[0] = DIGIT_SEGS[(last_cm / 100) % 10];
          digit_segs[1] = DIGIT_SEGS[(last_cm / 10) % 10];
          digit_segs[2] = DIGIT_SEGS[last_cm % 10];
          done      = 1'b1;
          seq_phase = PH_BEGIN;
        end
      end
      default: begin
        led_now  = LED_IDLE;
        tick_cnt = '0;
        if (hold) begin
          led_now   = LED_PAUSED;
          seq_phase = PH_HOLD;
        end else begin
          seq_phase = PH_SETTLE;
        end
      end
    endcase
    r.trigger      = (seq_phase == PH_TRIGGER);
    r.led          = led_now;
    r.seg_hundreds = digit_segs[0];
    r.seg_tens     = digit_segs[1];
    r.seg_ones     = digit_segs[2];
    r.distance_cm  = last_cm;
    r.measure_done = done;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Hold until every pending reading has come out and the pipe is quiet
  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // Drop the input stream, drain, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [27:0] val);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TRIGGER_TICKS:  trig_len_cfg   = val[15:0];
      CFG_SETTLE_TICKS:   settle_len_cfg = val;
      CFG_MAX_ECHO_TICKS: echo_cap_cfg   = val[23:0];
      CFG_SCALE_Q24:      scale_cfg      = val[15:0];
      default: ;
    endcase
  endtask

  // Offer one tick word, maybe after a short gap, and log its reading once accepted
  task automatic send_tick(input logic echo, input logic hold, input logic typed,
                           input reading_t want);
    reading_t r;
    if (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, hold, echo};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = advance_ranger(echo, hold);
    expected_readings.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  // One measurement cycle as the sensor would produce it, or a burst of noise
  task automatic run_episode();
    int unsigned pick;
    int unsigned lead;
    int unsigned width;
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(25, 5))
        send_tick(1'($urandom), 1'($urandom), 1'b0, NO_READING);
    end else begin
      // press the button for a while first
      if (pick < 30)
        repeat ($urandom_range(8, 1)) send_tick(1'($urandom), 1'b1, 1'b0, NO_READING);
      lead = settle_len_cfg + trig_len_cfg + 2 + $urandom_range(3);
      // echo arriving before the trigger is done
      if (pick >= 92) lead = $urandom_range(lead);
      repeat (lead) send_tick(1'b0, 1'b0, 1'b0, NO_READING);
      width = ($urandom_range(99) < 85) ? $urandom_range(60, 1) : $urandom_range(200, 61);
      repeat (width) send_tick(1'b1, 1'b0, 1'b0, NO_READING);
      repeat ($urandom_range(3, 1)) send_tick(1'b0, 1'($urandom), 1'b0, NO_READING);
    end
  endtask

  // Check each delivered word against the oldest pending reading; stall at random
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_readings.size() == 0) begin
        $error("output word with no reading pending");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("trigger", 32'(want.trigger), 32'(m_axis_tdata_o[0]));
        check_field("led_bits", 32'(want.led), 32'(m_axis_tdata_o[3:1]));
        check_field("seg_hundreds", 32'(want.seg_hundreds), 32'(m_axis_tdata_o[10:4]));
        check_field("seg_tens", 32'(want.seg_tens), 32'(m_axis_tdata_o[17:11]));
        check_field("seg_ones", 32'(want.seg_ones), 32'(m_axis_tdata_o[24:18]));
        check_field("distance_cm", 32'(want.distance_cm), 32'(m_axis_tdata_o[39:25]));
        check_field("measure_done", 32'(want.measure_done), 32'(m_axis_tuser_o[0]));
      end
    end
    m_axis_tready_i <= calm || ($urandom_range(99) >= 12);
  end

  // Watchdog: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    reset_ranger();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        repeat (PLAN[i].reps)
          send_tick(PLAN[i].echo, PLAN[i].hold, PLAN[i].typed, PLAN[i].want);
      end
    end

    // Random phases, each with its own short settle/trigger and random scaling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_TRIGGER_TICKS, (p == 0) ? 28'd0 : 28'($urandom_range(6, 1)));
      write_reg(CFG_SETTLE_TICKS, 28'($urandom_range(8)));
      write_reg(CFG_MAX_ECHO_TICKS,
                $urandom_range(1) ? 28'($urandom_range(400, 1)) : 28'hFFFFFF);
      write_reg(CFG_SCALE_Q24,
                (p == RANDOM_PHASES - 1) ? 28'($urandom_range(65535))
                                         : 28'($urandom_range(65535, 40000)));
      // one full phase with no idling on either side
      calm = (p == 2);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) run_episode();
      calm = 1'b0;
    end

    s_axis_tvalid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
